// ===== hdl/qdec_pkg.sv =====
// Shared types, constants and the decode function for the quadrature decoder.
package qdec_pkg;

    // Field widths fixed by the item format.
    localparam int OP_W    = 2;
    localparam int COUNT_W = 32;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 20;

    // One second in microseconds; also the saturated speed for a zero interval.
    localparam logic [SPEED_W-1:0] SPEED_SCALE = 20'd1000000;

    // Input operation codes.
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Classified command kinds.
    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_READ,
        KIND_CLEAR
    } cmd_kind_t;

    // One queued command from the front end to the back end.
    typedef struct packed {
        cmd_kind_t          kind;
        logic               pin_b;
        logic               pin_a_xor;
        logic [TIME_W-1:0]  time_us;
    } qdec_cmd_t;

    // Direction of one quadrature transition.
    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN
    } step_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_RING,
        BK_OUT
    } back_state_t;

    // Transition code is {new A, new B, old A, old B}.
    function automatic step_t qdec_step(input logic [3:0] code);
        step_t s;
        case (code)
            4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_DOWN;
            4'd2, 4'd4, 4'd11, 4'd13: s = STEP_UP;
            default:                  s = STEP_NONE;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/qdec_in_if.sv =====
// Input channel interface: valid/ready handshake with the input item fields.
interface qdec_in_if;
    logic                          valid;
    logic                          ready;
    logic [qdec_pkg::OP_W-1:0]     op;
    logic                          pin_b;
    logic                          pin_a_xor;
    logic [qdec_pkg::TIME_W-1:0]   time_us;

    modport source (output valid, output op, output pin_b, output pin_a_xor,
                    output time_us, input ready);
    modport sink   (input valid, input op, input pin_b, input pin_a_xor,
                    input time_us, output ready);
endinterface

// ===== hdl/qdec_out_if.sv =====
// Output channel interface: valid/ready handshake with the result item fields.
interface qdec_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [qdec_pkg::COUNT_W-1:0]  position_count;
    logic [qdec_pkg::SPEED_W-1:0]         tick_speed;

    modport source (output valid, output position_count, output tick_speed,
                    input ready);
    modport sink   (input valid, input position_count, input tick_speed,
                    output ready);
endinterface

// ===== hdl/quadrature_decoder_with_speed.sv =====
// Top level of the single-channel quadrature decoder with edge-rate speed estimate.
//
//  Channel   Role    Handshake     Carries
//  in_ch     sink    valid/ready   op, pin_b, pin_a_xor, time_us
//  out_ch    source  valid/ready   position_count, tick_speed
//
// A read or clear item passes from the queue straight into the result register once
// the output is free. A pin-change item passes through a start step, 20 reciprocal
// divider steps, a wait for the divider to finish, one ring update and the load of
// the result register.
// Items wait in a two-entry queue, so the input keeps taking transfers while
// the back end works or the output is stalled until two items are waiting.
// One result per item, in order. Reset is asynchronous and leaves the speed
// ring reading as all zero.
module quadrature_decoder_with_speed #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    qdec_in_if.sink      in_ch,
    qdec_out_if.source   out_ch
);
    import qdec_pkg::*;

    qdec_cmd_t  cmd;
    logic       cmd_valid;
    logic       cmd_pop;

    qdec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    qdec_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .out_ch    (out_ch)
    );

endmodule

// ===== hdl/qdec_front.sv =====
// Front end: accepts input items, classifies the operation and queues commands.
module qdec_front (
    input  logic                 clk,
    input  logic                 rst_n,
    qdec_in_if.sink              in_ch,
    output qdec_pkg::qdec_cmd_t  cmd,
    output logic                 cmd_valid,
    input  logic                 cmd_pop
);
    import qdec_pkg::*;

    qdec_cmd_t   fifo_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    logic        pop;
    qdec_cmd_t   new_cmd;

    // Classify the operation code; an unused code behaves as a plain read.
    always_comb
    begin
        new_cmd.pin_b     = in_ch.pin_b;
        new_cmd.pin_a_xor = in_ch.pin_a_xor;
        new_cmd.time_us   = in_ch.time_us;
        case (in_ch.op)
            OP_SAMPLE: new_cmd.kind = KIND_SAMPLE;
            OP_CLEAR:  new_cmd.kind = KIND_CLEAR;
            default:   new_cmd.kind = KIND_READ;
        endcase
    end

    // Two-entry queue control.
    assign in_ch.ready = (fill_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (fill_reg != 2'd0);
    assign pop         = cmd_pop && cmd_valid;
    assign cmd         = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== hdl/qdec_div.sv =====
// Restoring divider that forms one second divided by an interval, one bit a cycle.
module qdec_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [qdec_pkg::TIME_W-1:0]       divisor,
    output logic                              done,
    output logic [qdec_pkg::SPEED_W-1:0]      quotient
);
    import qdec_pkg::*;

    localparam int CNT_W = $clog2(SPEED_W);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [TIME_W-1:0]    div_reg;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [SPEED_W-1:0]   num_reg, num_next;
    logic [SPEED_W-1:0]   quo_reg, quo_next;
    logic                 zero_reg;
    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      diff;
    logic                 fits;

    // One restoring step: bring in the next dividend bit and try a subtract.
    assign trial = {rem_reg, num_reg[SPEED_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            num_next = SPEED_SCALE;
            quo_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            num_next = {num_reg[SPEED_W-2:0], 1'b0};
            quo_next = {quo_reg[SPEED_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(SPEED_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers; a zero interval saturates the result.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg  <= divisor;
            zero_reg <= (divisor == '0);
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? SPEED_SCALE : quo_reg;

endmodule

// ===== hdl/qdec_back.sv =====
// Back end: position counting, speed ring, running sum and the result register.
module qdec_back #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qdec_pkg::qdec_cmd_t  cmd,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    qdec_out_if.source           out_ch
);
    import qdec_pkg::*;

    localparam int IDX_BITS = $clog2(HISTORY_DEPTH);
    localparam int SLOT_W   = (HISTORY_DEPTH > 1) ? IDX_BITS : 1;
    localparam int SUM_W    = SPEED_W + IDX_BITS;

    back_state_t          state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg;
    logic                 last_a_reg, last_b_reg;
    logic [TIME_W-1:0]    prev_time_reg;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [SUM_W-1:0]     sum_reg;
    logic [HISTORY_DEPTH-1:0] hist_vld_reg;
    logic [SPEED_W-1:0]   hist_mem [HISTORY_DEPTH];
    logic [SPEED_W-1:0]   old_spd_reg;
    logic                 old_vld_reg;
    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic [SPEED_W-1:0]   out_speed_reg;

    logic                 out_free;
    logic                 start_sample;
    logic                 load_query;
    logic                 ring_write;
    logic                 load_out;
    logic                 new_a;
    step_t                step;
    logic [TIME_W-1:0]    elapsed;
    logic                 div_done;
    logic [SPEED_W-1:0]   speed;
    logic [SPEED_W-1:0]   old_speed;
    logic [SLOT_W-1:0]    slot_inc;

    assign out_free = !out_valid_reg || out_ch.ready;

    // Decode the pin levels into a count step.
    assign new_a   = cmd.pin_a_xor ^ cmd.pin_b;
    assign step    = qdec_step({new_a, cmd.pin_b, last_a_reg, last_b_reg});
    assign elapsed = cmd.time_us - prev_time_reg;

    qdec_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_sample),
        .divisor  (elapsed),
        .done     (div_done),
        .quotient (speed)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && cmd.kind == KIND_SAMPLE)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = BK_RING;
                end
            end
            BK_RING:
            begin
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        cmd_pop      = 1'b0;
        start_sample = 1'b0;
        load_query   = 1'b0;
        ring_write   = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && cmd.kind == KIND_SAMPLE)
                begin
                    cmd_pop      = 1'b1;
                    start_sample = 1'b1;
                end
                else if (cmd_valid && out_free)
                begin
                    cmd_pop    = 1'b1;
                    load_query = 1'b1;
                    load_out   = 1'b1;
                end
            end
            BK_RING:
            begin
                ring_write = 1'b1;
            end
            BK_OUT:
            begin
                load_out = out_free;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // Ring slot advance; a single-entry ring stays at slot zero.
    assign slot_inc  = slot_reg + SLOT_W'(1);
    assign slot_next = (HISTORY_DEPTH == 1) ? '0 : slot_inc;
    assign old_speed = old_vld_reg ? old_spd_reg : '0;

    // Control and running state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            last_a_reg    <= 1'b0;
            last_b_reg    <= 1'b0;
            prev_time_reg <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            hist_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start_sample)
            begin
                last_a_reg    <= new_a;
                last_b_reg    <= cmd.pin_b;
                prev_time_reg <= cmd.time_us;
                case (step)
                    STEP_UP:   count_reg <= count_reg + COUNT_W'(1);
                    STEP_DOWN: count_reg <= count_reg - COUNT_W'(1);
                    default:   count_reg <= count_reg;
                endcase
            end
            else if (load_query && cmd.kind == KIND_CLEAR)
            begin
                count_reg <= '0;
            end
            if (ring_write)
            begin
                sum_reg                <= sum_reg - SUM_W'(old_speed) + SUM_W'(speed);
                hist_vld_reg[slot_reg] <= 1'b1;
                slot_reg               <= slot_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Speed ring storage with registered read of the slot being replaced.
    always_ff @(posedge clk)
    begin
        if (start_sample)
        begin
            old_spd_reg <= hist_mem[slot_reg];
            old_vld_reg <= hist_vld_reg[slot_reg];
        end
        if (ring_write)
        begin
            hist_mem[slot_reg] <= speed;
        end
    end

    // Result register: count after a sample, before a clear; mean of the ring.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_count_reg <= count_reg;
            out_speed_reg <= sum_reg[IDX_BITS +: SPEED_W];
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.position_count = $signed(out_count_reg);
    assign out_ch.tick_speed     = out_speed_reg;

endmodule

// ===== hdl/qdec_checker.sv =====
// Port-level checks for the quadrature decoder, bound to the top level.
module qdec_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [qdec_pkg::COUNT_W-1:0]  position_count,
    input  logic [qdec_pkg::SPEED_W-1:0]         tick_speed
);
    import qdec_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

    // The mean speed never exceeds the saturated sample value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tick_speed <= SPEED_SCALE)
    else $error("mean speed out of range");

    // No result is offered in the first cycle after reset is released.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
    else $error("result offered straight out of reset");

    // With the queue full and the output stalled, the count on offer holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !in_ready && in_valid |=> $stable(position_count))
    else $error("stalled count changed");

endmodule

bind quadrature_decoder_with_speed qdec_checker u_qdec_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .position_count (out_ch.position_count),
    .tick_speed     (out_ch.tick_speed)
);
